// ----- src/vpr_pkg.sv -----
// ----------------------------------------------------------------------------
// vpr_pkg
// Shared types and constants of the vector polar/rotate unit: operation codes,
// CORDIC arctangent table in turn units, inverse gain and stage control type.
// ----------------------------------------------------------------------------
package vpr_pkg;

    localparam logic [1:0] FUNC_TO_POLAR   = 2'd0;
    localparam logic [1:0] FUNC_FROM_POLAR = 2'd1;
    localparam logic [1:0] FUNC_ROTATE     = 2'd2;

    localparam int GUARD   = 2;
    localparam int TURN_W  = 32;
    localparam int GAIN_W  = 31;

    // 1/K of the CORDIC, Q0.31
    localparam logic [GAIN_W-1:0] INV_GAIN = 31'd1304065748;

    localparam logic [TURN_W-1:0] TURN_HALF = 32'h8000_0000;

    // atan(2^-i) as a fraction of a full turn
    localparam logic [TURN_W-1:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic valid;
        logic vec;     // vectoring (to-polar) item
    } t_ctl;

endpackage

// ----- src/vector_polar_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// vector_polar_rotate_unit
// Pipelined CORDIC vector unit: to-polar, from-polar and point rotation on
// fixed-point coordinates, with a row of CORDIC cells between two gain
// scalers and an output register backed by a skid stage.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  -------  -------------------------  ----------------------------------------
//  input    i_in_valid / o_in_ready    i_func i_in_x i_in_y i_in_angle
//                                      i_in_radius
//  output   o_out_valid / i_out_ready  o_out_x o_out_y o_out_angle
//                                      o_out_radius o_saturated
//
//  One item per cycle unless the skid stage is full. Stages: prep, three gain
//  stages, one cell per CORDIC step, three gain stages, output register.
//  Reset clears all valid bits; no warm-up.
//  A stalled output fills the skid stage, then the whole pipe holds and
//  o_in_ready drops until the skid item moves to the output register.
// ----------------------------------------------------------------------------
module vector_polar_rotate_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 32,
    parameter int ANGLE_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_func,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    input  logic [ANGLE_WIDTH-1:0]        i_in_angle,
    input  logic [COORD_WIDTH-2:0]        i_in_radius,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic [ANGLE_WIDTH-1:0]        o_out_angle,
    output logic [COORD_WIDTH-1:0]        o_out_radius,
    output logic                          o_saturated
);

    localparam int CW      = COORD_WIDTH;
    localparam int AW      = ANGLE_WIDTH;
    localparam int GD      = vpr_pkg::GUARD;
    localparam int TW      = vpr_pkg::TURN_W;
    localparam int DATA_W  = CW + GD + 3;
    localparam int SIDE_W  = 3 + AW + CW;
    localparam int ZSIDE_W = TW + SIDE_W;
    localparam int RES_W   = 3 * CW + AW + 1;

    localparam logic signed [DATA_W-1:0] ROUND_GD = DATA_W'(1) << (GD - 1);
    localparam logic [TW-1:0]            ROUND_AW = TW'(1) << (TW - 1 - AW);
    localparam logic [AW-1:0]            EIGHTH   = AW'(1) << (AW - 3);

    logic w_en;

    // ---------------- prep stage ----------------
    logic signed [DATA_W-1:0] w_x4, w_y4, w_r4, w_bx, w_by;
    logic [CW-1:0]            w_ax, w_ay;
    logic                     w_xz, w_yz, w_special;
    logic [1:0]               w_sp_k, w_q;
    logic [CW-1:0]            w_sp_rad;
    logic [AW-1:0]            w_asum, w_rest;

    vpr_pkg::t_ctl            n_s1_ctl, r_s1_ctl;
    logic signed [DATA_W-1:0] n_s1_x, n_s1_y, r_s1_x, r_s1_y;
    logic [TW-1:0]            n_s1_z;
    logic [ZSIDE_W-1:0]       r_s1_side;

    always_comb begin
        w_x4 = {{(DATA_W - CW - GD){i_in_x[CW-1]}}, i_in_x, {GD{1'b0}}};
        w_y4 = {{(DATA_W - CW - GD){i_in_y[CW-1]}}, i_in_y, {GD{1'b0}}};
        w_r4 = {{(DATA_W - CW + 1 - GD){1'b0}}, i_in_radius, {GD{1'b0}}};
        w_ax = i_in_x[CW-1] ? (~i_in_x + CW'(1)) : i_in_x;
        w_ay = i_in_y[CW-1] ? (~i_in_y + CW'(1)) : i_in_y;
        w_xz = (i_in_x == '0);
        w_yz = (i_in_y == '0);
        w_special = w_xz | w_yz;

        // for to-polar, axis points and origin bypass the CORDIC
        if (w_xz && w_yz) begin
            w_sp_k   = 2'd0;
            w_sp_rad = '0;
        end else if (w_xz) begin
            w_sp_k   = i_in_y[CW-1] ? 2'd3 : 2'd1;
            w_sp_rad = w_ay;
        end else begin
            w_sp_k   = i_in_x[CW-1] ? 2'd2 : 2'd0;
            w_sp_rad = w_ax;
        end

        // quarter-turn pre-rotation, remainder within an eighth turn
        w_asum = i_in_angle + EIGHTH;
        w_q    = w_asum[AW-1 -: 2];
        w_rest = i_in_angle - {w_q, {(AW - 2){1'b0}}};

        w_bx = (i_func == vpr_pkg::FUNC_FROM_POLAR) ? w_r4 : w_x4;
        w_by = (i_func == vpr_pkg::FUNC_FROM_POLAR) ? '0 : w_y4;

        n_s1_ctl.valid = i_in_valid;
        n_s1_ctl.vec   = (i_func == vpr_pkg::FUNC_TO_POLAR);

        if (n_s1_ctl.vec) begin
            if (i_in_x[CW-1]) begin
                n_s1_x = -w_x4;
                n_s1_y = -w_y4;
                n_s1_z = vpr_pkg::TURN_HALF;
            end else begin
                n_s1_x = w_x4;
                n_s1_y = w_y4;
                n_s1_z = '0;
            end
        end else begin
            n_s1_z = {w_rest, {(TW - AW){1'b0}}};
            case (w_q)
                2'd1: begin
                    n_s1_x = -w_by;
                    n_s1_y = w_bx;
                end
                2'd2: begin
                    n_s1_x = -w_bx;
                    n_s1_y = -w_by;
                end
                2'd3: begin
                    n_s1_x = w_by;
                    n_s1_y = -w_bx;
                end
                default: begin
                    n_s1_x = w_bx;
                    n_s1_y = w_by;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (w_en) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x    <= n_s1_x;
            r_s1_y    <= n_s1_y;
            r_s1_side <= {n_s1_z, i_func, w_special, w_sp_k, {(AW - 2){1'b0}}, w_sp_rad};
        end
    end

    // ---------------- pre-scale ----------------
    vpr_pkg::t_ctl            w_g_ctl;
    logic signed [DATA_W-1:0] w_g_x, w_g_y;
    logic [ZSIDE_W-1:0]       w_g_side;

    vpr_gain #(
        .DATA_W    (DATA_W),
        .SIDE_W    (ZSIDE_W),
        .SCALE_VEC (1'b0)
    ) u_gain_pre (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_ctl  (r_s1_ctl),
        .i_x    (r_s1_x),
        .i_y    (r_s1_y),
        .i_side (r_s1_side),
        .o_ctl  (w_g_ctl),
        .o_x    (w_g_x),
        .o_y    (w_g_y),
        .o_side (w_g_side)
    );

    // ---------------- CORDIC cells ----------------
    vpr_pkg::t_ctl            w_c_ctl  [CORDIC_STEPS+1];
    logic signed [DATA_W-1:0] w_c_x    [CORDIC_STEPS+1];
    logic signed [DATA_W-1:0] w_c_y    [CORDIC_STEPS+1];
    logic [TW-1:0]            w_c_z    [CORDIC_STEPS+1];
    logic [SIDE_W-1:0]        w_c_side [CORDIC_STEPS+1];

    assign w_c_ctl[0]  = w_g_ctl;
    assign w_c_x[0]    = w_g_x;
    assign w_c_y[0]    = w_g_y;
    assign w_c_z[0]    = w_g_side[ZSIDE_W-1 -: TW];
    assign w_c_side[0] = w_g_side[SIDE_W-1:0];

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
        vpr_cell #(
            .DATA_W(DATA_W),
            .SIDE_W(SIDE_W),
            .STAGE (s)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_ctl  (w_c_ctl[s]),
            .i_x    (w_c_x[s]),
            .i_y    (w_c_y[s]),
            .i_z    (w_c_z[s]),
            .i_side (w_c_side[s]),
            .o_ctl  (w_c_ctl[s+1]),
            .o_x    (w_c_x[s+1]),
            .o_y    (w_c_y[s+1]),
            .o_z    (w_c_z[s+1]),
            .o_side (w_c_side[s+1])
        );
    end

    // ---------------- post-scale ----------------
    vpr_pkg::t_ctl            w_post_ctl;
    logic signed [DATA_W-1:0] w_post_x, w_post_y;
    logic [ZSIDE_W-1:0]       w_post_side;

    vpr_gain #(
        .DATA_W    (DATA_W),
        .SIDE_W    (ZSIDE_W),
        .SCALE_VEC (1'b1)
    ) u_gain_post (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_ctl  (w_c_ctl[CORDIC_STEPS]),
        .i_x    (w_c_x[CORDIC_STEPS]),
        .i_y    (w_c_y[CORDIC_STEPS]),
        .i_side ({w_c_z[CORDIC_STEPS], w_c_side[CORDIC_STEPS]}),
        .o_ctl  (w_post_ctl),
        .o_x    (w_post_x),
        .o_y    (w_post_y),
        .o_side (w_post_side)
    );

    // ---------------- finish ----------------
    logic [TW-1:0]            w_f_z, w_f_zr;
    logic [1:0]               w_f_func;
    logic                     w_f_special;
    logic [AW-1:0]            w_f_sp_ang, w_f_ang;
    logic [CW-1:0]            w_f_sp_rad, w_f_rad;
    logic signed [DATA_W-1:0] w_rx, w_ry;
    logic [DATA_W-CW:0]       w_hx, w_hy;
    logic                     w_ovx, w_ovy;
    logic [CW-1:0]            w_fx, w_fy;
    logic [RES_W-1:0]         w_res;

    always_comb begin
        w_f_z       = w_post_side[ZSIDE_W-1 -: TW];
        w_f_func    = w_post_side[CW+AW+2 -: 2];
        w_f_special = w_post_side[CW+AW];
        w_f_sp_ang  = w_post_side[CW+AW-1 -: AW];
        w_f_sp_rad  = w_post_side[CW-1:0];

        w_rx = (w_post_x + ROUND_GD) >>> GD;
        w_ry = (w_post_y + ROUND_GD) >>> GD;

        w_f_zr  = w_f_z + ROUND_AW;
        w_f_ang = w_f_zr[TW-1 -: AW];
        if (w_rx[DATA_W-1]) begin
            w_f_rad = '0;
        end else if (|w_rx[DATA_W-2:CW]) begin
            w_f_rad = '1;
        end else begin
            w_f_rad = w_rx[CW-1:0];
        end

        w_hx  = w_rx[DATA_W-1:CW-1];
        w_hy  = w_ry[DATA_W-1:CW-1];
        w_ovx = !((&w_hx) | ~(|w_hx));
        w_ovy = !((&w_hy) | ~(|w_hy));
        w_fx  = w_ovx ? {w_rx[DATA_W-1], {(CW - 1){~w_rx[DATA_W-1]}}} : w_rx[CW-1:0];
        w_fy  = w_ovy ? {w_ry[DATA_W-1], {(CW - 1){~w_ry[DATA_W-1]}}} : w_ry[CW-1:0];

        case (w_f_func)
            vpr_pkg::FUNC_TO_POLAR: begin
                if (w_f_special) begin
                    w_res = {{(2 * CW){1'b0}}, w_f_sp_ang, w_f_sp_rad, 1'b0};
                end else begin
                    w_res = {{(2 * CW){1'b0}}, w_f_ang, w_f_rad, 1'b0};
                end
            end
            vpr_pkg::FUNC_FROM_POLAR, vpr_pkg::FUNC_ROTATE: begin
                w_res = {w_fx, w_fy, {(AW + CW){1'b0}}, w_ovx | w_ovy};
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // ---------------- output register and skid ----------------
    logic             r_out_valid, r_skid_valid;
    logic [RES_W-1:0] r_out, r_skid;
    logic             w_load_skid2out, w_load_fin2out, w_load_fin2skid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    always_comb begin
        w_load_skid2out = r_skid_valid && i_out_ready;
        w_load_fin2out  = !r_skid_valid && w_post_ctl.valid && (!r_out_valid || i_out_ready);
        w_load_fin2skid = !r_skid_valid && w_post_ctl.valid && r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_load_skid2out || w_load_fin2out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load_skid2out) begin
                r_skid_valid <= 1'b0;
            end else if (w_load_fin2skid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_skid2out) begin
            r_out <= r_skid;
        end else if (w_load_fin2out) begin
            r_out <= w_res;
        end
        if (w_load_fin2skid) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_x      = r_out[RES_W-1 -: CW];
    assign o_out_y      = r_out[RES_W-CW-1 -: CW];
    assign o_out_angle  = r_out[AW+CW -: AW];
    assign o_out_radius = r_out[CW:1];
    assign o_saturated  = r_out[0];

    // ---------------- checks ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid item held with empty output register");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid filled without an output stall");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> ($stable(w_post_ctl) && $stable(w_post_x) && $stable(w_post_y)))
        else $error("pipeline moved while skid was full");

    a_sat_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_out_angle == '0 && o_out_radius == '0))
        else $error("saturated item carries polar fields");

endmodule

// ----- src/vpr_gain.sv -----
// ----------------------------------------------------------------------------
// vpr_gain
// Three-stage inverse CORDIC gain scaler for an x/y pair, round half away
// from zero, with a bypass path selected per item.
// ----------------------------------------------------------------------------
module vpr_gain #(
    parameter int DATA_W    = 37,
    parameter int SIDE_W    = 8,
    parameter bit SCALE_VEC = 1'b0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  vpr_pkg::t_ctl            i_ctl,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    input  logic [SIDE_W-1:0]        i_side,
    output vpr_pkg::t_ctl            o_ctl,
    output logic signed [DATA_W-1:0] o_x,
    output logic signed [DATA_W-1:0] o_y,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int HI_W  = (DATA_W > 32) ? DATA_W - 32 : 1;
    localparam int PAD_W = HI_W + 32;
    localparam int PHI_W = HI_W + vpr_pkg::GAIN_W;
    localparam int PLO_W = 32 + vpr_pkg::GAIN_W;
    localparam int SUM_W = PAD_W + 2;
    localparam logic [PLO_W-1:0] ROUND_LO = PLO_W'(1) << (vpr_pkg::GAIN_W - 1);

    logic signed [DATA_W-1:0] w_in [2];

    vpr_pkg::t_ctl            r_s1_ctl, r_s2_ctl, r_s3_ctl;
    logic                     r_s1_byp, r_s2_byp;
    logic                     r_s1_neg [2];
    logic                     r_s2_neg [2];
    logic [DATA_W-1:0]        r_s1_mag [2];
    logic signed [DATA_W-1:0] r_s1_raw [2];
    logic signed [DATA_W-1:0] r_s2_raw [2];
    logic [PHI_W-1:0]         r_s2_phi [2];
    logic [PLO_W-1:0]         r_s2_plo [2];
    logic signed [DATA_W-1:0] r_s3_out [2];
    logic [SIDE_W-1:0]        r_s1_side, r_s2_side, r_s3_side;

    logic [PAD_W-1:0]         w_pad [2];
    logic [SUM_W-1:0]         w_sum [2];
    logic [DATA_W-1:0]        w_mag [2];
    logic signed [DATA_W-1:0] n_s3_out [2];

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_pad[l]    = PAD_W'(r_s1_mag[l]);
            w_sum[l]    = SUM_W'({r_s2_phi[l], 1'b0})
                        + SUM_W'((r_s2_plo[l] + ROUND_LO) >> vpr_pkg::GAIN_W);
            w_mag[l]    = w_sum[l][DATA_W-1:0];
            n_s3_out[l] = r_s2_byp ? r_s2_raw[l]
                        : (r_s2_neg[l] ? -$signed(w_mag[l]) : $signed(w_mag[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_byp  <= (i_ctl.vec != SCALE_VEC);
            r_s2_byp  <= r_s1_byp;
            r_s1_side <= i_side;
            r_s2_side <= r_s1_side;
            r_s3_side <= r_s2_side;
            for (int l = 0; l < 2; l++) begin
                r_s1_neg[l] <= w_in[l][DATA_W-1];
                r_s1_mag[l] <= w_in[l][DATA_W-1] ? DATA_W'(-w_in[l]) : DATA_W'(w_in[l]);
                r_s1_raw[l] <= w_in[l];
                r_s2_neg[l] <= r_s1_neg[l];
                r_s2_raw[l] <= r_s1_raw[l];
                r_s2_phi[l] <= PHI_W'(w_pad[l][PAD_W-1:32]) * PHI_W'(vpr_pkg::INV_GAIN);
                r_s2_plo[l] <= PLO_W'(w_pad[l][31:0]) * PLO_W'(vpr_pkg::INV_GAIN);
                r_s3_out[l] <= n_s3_out[l];
            end
        end
    end

    assign o_ctl  = r_s3_ctl;
    assign o_x    = r_s3_out[0];
    assign o_y    = r_s3_out[1];
    assign o_side = r_s3_side;

endmodule

// ----- src/vpr_cell.sv -----
// ----------------------------------------------------------------------------
// vpr_cell
// One CORDIC micro-rotation stage, rotation or vectoring mode per item.
// ----------------------------------------------------------------------------
module vpr_cell #(
    parameter int DATA_W = 37,
    parameter int SIDE_W = 8,
    parameter int STAGE  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  vpr_pkg::t_ctl               i_ctl,
    input  logic signed [DATA_W-1:0]    i_x,
    input  logic signed [DATA_W-1:0]    i_y,
    input  logic [vpr_pkg::TURN_W-1:0]  i_z,
    input  logic [SIDE_W-1:0]           i_side,
    output vpr_pkg::t_ctl               o_ctl,
    output logic signed [DATA_W-1:0]    o_x,
    output logic signed [DATA_W-1:0]    o_y,
    output logic [vpr_pkg::TURN_W-1:0]  o_z,
    output logic [SIDE_W-1:0]           o_side
);

    localparam logic [vpr_pkg::TURN_W-1:0] ATAN = vpr_pkg::ATAN_TURN[STAGE];

    vpr_pkg::t_ctl                r_ctl;
    logic signed [DATA_W-1:0]     r_x, r_y;
    logic [vpr_pkg::TURN_W-1:0]   r_z;
    logic [SIDE_W-1:0]            r_side;

    logic signed [DATA_W-1:0]     w_dx, w_dy;
    logic                         w_sub;
    logic signed [DATA_W-1:0]     n_x, n_y;
    logic [vpr_pkg::TURN_W-1:0]   n_z;

    always_comb begin
        w_dx  = i_y >>> STAGE;
        w_dy  = i_x >>> STAGE;
        // turn toward negative angle: z below zero, or y at or above the axis
        w_sub = i_ctl.vec ? ~i_y[DATA_W-1] : i_z[vpr_pkg::TURN_W-1];
        if (w_sub) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vector_polar_rotate_unit. A short directed list
// (origin, axis points, range corners, quadrant edges, overflow) is followed
// by random items run in three phases with different idle and stall patterns
// on both channels. One phase includes a long output hold. Every accepted
// item is scored against a bit-exact CORDIC prediction computed in the bench.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD     = 8;
    localparam int STEPS          = 16;
    localparam int COORD_W        = 32;
    localparam int ANGLE_W        = 16;
    localparam int RANDOM_PER_PH  = 180;
    localparam int RX_HOLD_CYCLES = 160;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 4000;
    localparam int COORD_NEAR     = 1 << 20;

    localparam logic [ANGLE_W-1:0] ANG_QUARTER = ANGLE_W'(1) << (ANGLE_W - 2);
    localparam logic [ANGLE_W-1:0] ANG_HALF    = ANGLE_W'(1) << (ANGLE_W - 1);
    localparam logic [ANGLE_W-1:0] ANG_3Q      = ANG_HALF + ANG_QUARTER;
    localparam longint COORD_MAX  = 64'sd2147483647;
    localparam longint COORD_MIN  = -64'sd2147483648;
    localparam longint RADIUS_MAX = 64'sd4294967295;

    localparam logic signed [COORD_W-1:0] X_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] X_MIN = 32'sh8000_0000;
    localparam logic [COORD_W-2:0]        R_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]                  func;
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic [ANGLE_W-1:0]          angle;
        logic [COORD_W-2:0]          radius;
    } t_vec_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic [ANGLE_W-1:0]          angle;
        logic [COORD_W-1:0]          radius;
        logic                        sat;
    } t_vec_result;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        i_out_ready = 1'b0;
    logic [1:0]                  i_func      = '0;
    logic signed [COORD_W-1:0]   i_in_x      = '0;
    logic signed [COORD_W-1:0]   i_in_y      = '0;
    logic [ANGLE_W-1:0]          i_in_angle  = '0;
    logic [COORD_W-2:0]          i_in_radius = '0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic signed [COORD_W-1:0]   o_out_x;
    logic signed [COORD_W-1:0]   o_out_y;
    logic [ANGLE_W-1:0]          o_out_angle;
    logic [COORD_W-1:0]          o_out_radius;
    logic                        o_saturated;

    t_vec_item   pending_items [$];
    t_vec_result expected_results [$];
    t_vec_item   drv_item;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit rx_hold_req   = 1'b0;
    bit rx_hold_done  = 1'b0;
    int rx_hold_left  = 0;
    int idle_cycles   = 0;
    int n_errors      = 0;
    int n_results     = 0;
    int n_saturated   = 0;
    int n_func [3]    = '{0, 0, 0};

    vector_polar_rotate_unit #(
        .CORDIC_STEPS (STEPS),
        .COORD_WIDTH  (COORD_W),
        .ANGLE_WIDTH  (ANGLE_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_angle   (i_in_angle),
        .i_in_radius  (i_in_radius),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_angle  (o_out_angle),
        .o_out_radius (o_out_radius),
        .o_saturated  (o_saturated)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // magnitude times 1/K, rounded half away from zero
    function automatic longint gain_scale(longint v);
        bit [63:0] m;
        bit [63:0] r;
        m = (v < 0) ? -v : v;
        r = (m >> 32) * 64'(vpr_pkg::INV_GAIN) * 2
            + (((m & 64'hFFFF_FFFF) * 64'(vpr_pkg::INV_GAIN) + 64'h4000_0000) >> 31);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    // drop guard bits with half-LSB rounding, clamp to coordinate range
    function automatic logic [COORD_W-1:0] clamp_coord(longint v, inout bit sat);
        longint r;
        r = (v + (longint'(1) << (vpr_pkg::GUARD - 1))) >>> vpr_pkg::GUARD;
        if (r > COORD_MAX) begin
            sat = 1'b1;
            r = COORD_MAX;
        end else if (r < COORD_MIN) begin
            sat = 1'b1;
            r = COORD_MIN;
        end
        return r[COORD_W-1:0];
    endfunction

    function automatic t_vec_result predict_vector(t_vec_item it);
        t_vec_result res;
        longint px, py, tmp, zs, dx, dy;
        bit [vpr_pkg::TURN_W-1:0] zv, turn, rest, tsum;
        bit [1:0] q;
        bit [vpr_pkg::TURN_W:0] ang_w;
        bit sat;
        res = '0;
        px = longint'($signed(it.x));
        py = longint'($signed(it.y));
        if (it.func == vpr_pkg::FUNC_TO_POLAR) begin
            if (px == 0 && py == 0) begin
                res.angle  = '0;
                res.radius = '0;
            end else if (px == 0) begin
                res.angle  = (py > 0) ? ANG_QUARTER : ANG_3Q;
                res.radius = COORD_W'((py > 0) ? py : -py);
            end else if (py == 0) begin
                res.angle  = (px > 0) ? '0 : ANG_HALF;
                res.radius = COORD_W'((px > 0) ? px : -px);
            end else begin
                px = px <<< vpr_pkg::GUARD;
                py = py <<< vpr_pkg::GUARD;
                zv = '0;
                if (px < 0) begin
                    px = -px;
                    py = -py;
                    zv = vpr_pkg::TURN_HALF;
                end
                for (int i = 0; i < STEPS; i++) begin
                    dx = py >>> i;
                    dy = px >>> i;
                    if (py >= 0) begin
                        px = px + dx;
                        py = py - dy;
                        zv = zv + vpr_pkg::ATAN_TURN[i];
                    end else begin
                        px = px - dx;
                        py = py + dy;
                        zv = zv - vpr_pkg::ATAN_TURN[i];
                    end
                end
                ang_w = {1'b0, zv}
                      + ((vpr_pkg::TURN_W + 1)'(1) << (vpr_pkg::TURN_W - 1 - ANGLE_W));
                res.angle = ang_w[vpr_pkg::TURN_W-1 -: ANGLE_W];
                tmp = (gain_scale(px) + (longint'(1) << (vpr_pkg::GUARD - 1)))
                      >>> vpr_pkg::GUARD;
                if (tmp < 0) tmp = 0;
                if (tmp > RADIUS_MAX) tmp = RADIUS_MAX;
                res.radius = tmp[COORD_W-1:0];
            end
        end else if (it.func == vpr_pkg::FUNC_FROM_POLAR || it.func == vpr_pkg::FUNC_ROTATE) begin
            if (it.func == vpr_pkg::FUNC_FROM_POLAR) begin
                px = gain_scale(longint'(it.radius) <<< vpr_pkg::GUARD);
                py = 0;
            end else begin
                px = gain_scale(px <<< vpr_pkg::GUARD);
                py = gain_scale(py <<< vpr_pkg::GUARD);
            end
            turn = vpr_pkg::TURN_W'(it.angle) << (vpr_pkg::TURN_W - ANGLE_W);
            tsum = turn + (vpr_pkg::TURN_HALF >> 2);
            q    = tsum[vpr_pkg::TURN_W-1 -: 2];
            rest = turn - {q, 30'b0};
            zs   = longint'($signed(rest));
            case (q)
                2'd1: begin
                    tmp = px;
                    px  = -py;
                    py  = tmp;
                end
                2'd2: begin
                    px = -px;
                    py = -py;
                end
                2'd3: begin
                    tmp = px;
                    px  = py;
                    py  = -tmp;
                end
                default: ;
            endcase
            for (int i = 0; i < STEPS; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (zs >= 0) begin
                    px = px - dx;
                    py = py + dy;
                    zs = zs - longint'(vpr_pkg::ATAN_TURN[i]);
                end else begin
                    px = px + dx;
                    py = py - dy;
                    zs = zs + longint'(vpr_pkg::ATAN_TURN[i]);
                end
            end
            sat = 1'b0;
            res.x   = clamp_coord(px, sat);
            res.y   = clamp_coord(py, sat);
            res.sat = sat;
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return '0;
            1: begin
                case ($urandom_range(3))
                    0: return X_MAX;
                    1: return X_MIN;
                    2: return 1;
                    default: return -1;
                endcase
            end
            2, 3, 4: return $signed($urandom_range(2 * COORD_NEAR)) - COORD_NEAR;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic [1:0] func, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [ANGLE_W-1:0] angle,
                             input logic [COORD_W-2:0] radius);
        t_vec_item it;
        it.func   = func;
        it.x      = x;
        it.y      = y;
        it.angle  = angle;
        it.radius = radius;
        pending_items.push_back(it);
    endtask

    task automatic note_mismatch(input string msg);
        if (n_errors < 10) $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_vector(drv_item));
                n_func[drv_item.func]++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    drv_item    = pending_items.pop_front();
                    i_in_valid  <= 1'b1;
                    i_func      <= drv_item.func;
                    i_in_x      <= drv_item.x;
                    i_in_y      <= drv_item.y;
                    i_in_angle  <= drv_item.angle;
                    i_in_radius <= drv_item.radius;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_vec_result got;
        t_vec_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got.x      = o_out_x;
                got.y      = o_out_y;
                got.angle  = o_out_angle;
                got.radius = o_out_radius;
                got.sat    = o_saturated;
                n_results++;
                if (o_saturated === 1'b1) n_saturated++;
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result x=%h y=%h ang=%h r=%h sat=%b",
                        got.x, got.y, got.angle, got.radius, got.sat));
                end else begin
                    want = expected_results.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.angle !== want.angle
                            || got.radius !== want.radius || got.sat !== want.sat)
                        note_mismatch($sformatf(
                            "exp x=%h y=%h ang=%h r=%h sat=%b / got x=%h y=%h ang=%h r=%h sat=%b",
                            want.x, want.y, want.angle, want.radius, want.sat,
                            got.x, got.y, got.angle, got.radius, got.sat));
                end
            end
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_left = RX_HOLD_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int tx_idle_by_phase [3];
        int rx_idle_by_phase [3];
        logic [1:0] fn;
        logic [ANGLE_W-1:0] ang;
        logic [COORD_W-2:0] rad;
        tx_idle_by_phase = '{9, 72, 0};
        rx_idle_by_phase = '{72, 9, 0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // origin, axis points, range corners
        push_item(vpr_pkg::FUNC_TO_POLAR, 0, 0, ANGLE_W'($urandom), (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, 5 << 16, 0, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, X_MIN, 0, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, 0, X_MAX, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, 0, X_MIN, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, 0, -(3 << 16), ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, X_MAX, X_MAX, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, X_MIN, X_MIN, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, X_MIN, X_MAX, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, 1, -1, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_TO_POLAR, -(3 << 16), 4 << 16, ANGLE_W'($urandom),
                  (COORD_W-1)'($urandom));
        // from-polar, quadrant edges and full-range radius
        push_item(vpr_pkg::FUNC_FROM_POLAR, $urandom, $urandom, 16'h0000, '0);
        push_item(vpr_pkg::FUNC_FROM_POLAR, $urandom, $urandom, 16'h0000, R_MAX);
        push_item(vpr_pkg::FUNC_FROM_POLAR, $urandom, $urandom, 16'h2000, R_MAX);
        push_item(vpr_pkg::FUNC_FROM_POLAR, $urandom, $urandom, 16'h4000,
                  (COORD_W-1)'(1 << 16));
        push_item(vpr_pkg::FUNC_FROM_POLAR, $urandom, $urandom, 16'hC000,
                  (COORD_W-1)'(1 << 16));
        push_item(vpr_pkg::FUNC_FROM_POLAR, $urandom, $urandom, 16'hFFFF, R_MAX);
        // rotation, overflow and octant boundaries
        push_item(vpr_pkg::FUNC_ROTATE, X_MAX, X_MAX, 16'h2000, (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_ROTATE, X_MIN, X_MIN, 16'h6000, (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_ROTATE, 3 << 16, -(2 << 16), 16'h8000,
                  (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_ROTATE, 1 << 16, 1 << 16, 16'hE000, (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_ROTATE, X_MAX, X_MIN, 16'h0000, (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_ROTATE, -1, 1, 16'h1FFF, (COORD_W-1)'($urandom));
        push_item(vpr_pkg::FUNC_ROTATE, 1 << 16, 0, 16'hDFFF, (COORD_W-1)'($urandom));
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_idle_by_phase[ph];
            rx_idle_pct = rx_idle_by_phase[ph];
            for (int n = 0; n < RANDOM_PER_PH; n++) begin
                fn = 2'($urandom_range(2));
                if ($urandom_range(3) == 0)
                    ang = ANGLE_W'(($urandom_range(7) << (ANGLE_W - 3))
                                   + $urandom_range(4) - 2);
                else
                    ang = ANGLE_W'($urandom);
                case ($urandom_range(5))
                    0: rad = (COORD_W-1)'($urandom_range(COORD_NEAR));
                    1: rad = (COORD_W-1)'(R_MAX - $urandom_range(3));
                    default: rad = (COORD_W-1)'($urandom);
                endcase
                push_item(fn, rand_coord(), rand_coord(), ang, rad);
            end
            if (ph == 2) rx_hold_req = 1'b1;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            $display("%0d expected results never arrived", expected_results.size());
        $display("covered %0d to-polar, %0d from-polar, %0d rotate items; %0d results checked",
                 n_func[vpr_pkg::FUNC_TO_POLAR], n_func[vpr_pkg::FUNC_FROM_POLAR],
                 n_func[vpr_pkg::FUNC_ROTATE], n_results);
        $display("%0d saturated results seen, %0d mismatches", n_saturated, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
